/* hdl/bgpfsm_pkg.sv */
// bgpfsm_pkg: shared types, codes and timer helpers for the bgp session controller
// no dependencies; used by bgpfsm_step, bgp_session_fsm and bgpfsm_checker
`timescale 1ns / 1ps

package bgpfsm_pkg;

	// event kinds
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_STOP   = 2'd1;
	localparam logic [1:0] CMD_PACKET = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	// received packet kinds
	localparam logic [2:0] PK_OPEN      = 3'd0;
	localparam logic [2:0] PK_UPDATE    = 3'd1;
	localparam logic [2:0] PK_NOTIFY    = 3'd2;
	localparam logic [2:0] PK_KEEPALIVE = 3'd3;
	localparam logic [2:0] PK_OTHER     = 3'd4;

	// session states
	localparam logic [1:0] ST_IDLE         = 2'd0;
	localparam logic [1:0] ST_OPEN_SENT    = 2'd1;
	localparam logic [1:0] ST_OPEN_CONFIRM = 2'd2;
	localparam logic [1:0] ST_ESTABLISHED  = 2'd3;

	// notification codes and subcodes
	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_OPEN  = 3'd2;
	localparam logic [2:0] ERR_HOLD  = 3'd4;
	localparam logic [2:0] ERR_FSM   = 3'd5;
	localparam logic [2:0] ERR_CEASE = 3'd6;

	localparam logic [2:0] SUB_NONE          = 3'd0;
	localparam logic [2:0] SUB_BAD_VERSION   = 3'd1;
	localparam logic [2:0] SUB_BAD_ROUTER_ID = 3'd3;
	localparam logic [2:0] SUB_BAD_HOLD      = 3'd6;
	localparam logic [2:0] SUB_FSM_OPEN_SENT = 3'd1;
	localparam logic [2:0] SUB_FSM_CONFIRM   = 3'd2;
	localparam logic [2:0] SUB_FSM_ESTAB     = 3'd3;

	// result status codes
	localparam logic [2:0] RS_OK          = 3'd0;
	localparam logic [2:0] RS_UPDATE      = 3'd1;
	localparam logic [2:0] RS_BAD_TYPE    = 3'd2;
	localparam logic [2:0] RS_BAD_VERSION = 3'd3;
	localparam logic [2:0] RS_INVALID     = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_LOCAL_AS   = 2'd0;
	localparam logic [1:0] CFG_LOCAL_HOLD = 2'd1;
	localparam logic [1:0] CFG_KEEPALIVE  = 2'd2;
	localparam logic [1:0] CFG_FOUR_BYTE  = 2'd3;

	// protocol constants
	localparam logic [7:0]  BGP_VERSION   = 8'd4;
	localparam logic [15:0] HOLD_MIN      = 16'd3;
	localparam logic [15:0] AS_TRANS      = 16'd23456;
	localparam logic [31:0] AS16_MAX      = 32'd65535;

	// register reset values
	localparam logic [31:0] RST_LOCAL_AS  = 32'd23456;
	localparam logic [15:0] RST_LOCAL_HLD = 16'd90;
	localparam logic [15:0] RST_KEEPALIVE = 16'd30;
	localparam logic        RST_FOUR_BYTE = 1'b1;

	// timer values are kept in milliseconds; 65535 s * 1000 fits in 26 bits
	localparam int MS_W = 26;
	localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);
	localparam logic [MS_W-1:0] RST_HOLD_MS = MS_W'(90000);
	localparam logic [MS_W-1:0] RST_KA_MS   = MS_W'(30000);
	localparam logic [14:0]     RST_THIRD   = 15'd30;

	// floor(x / 3) for 16-bit x as (x * 43691) >> 17
	localparam logic [32:0] THIRD_RECIP = 33'd43691;
	localparam int          THIRD_SHIFT = 17;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  kind;
		logic [7:0]  version;
		logic [15:0] hold;
		logic [31:0] router_id;
		logic [31:0] as_num;
		logic [63:0] now;
	} item_t;

	typedef struct packed {
		logic [1:0]      sess;
		logic [31:0]     remote_as;
		logic [31:0]     remote_id;
		logic [MS_W-1:0] hold_ms;
		logic [MS_W-1:0] ka_ms;
		logic [63:0]     clock_now;
		logic [63:0]     last_heard;
		logic [63:0]     last_ka;
		logic            clock_valid;
	} sess_t;

	typedef struct packed {
		logic [31:0]     local_as;
		logic            four_byte;
		logic [MS_W-1:0] pl_ms;
		logic [MS_W-1:0] eff_pl_ms;
	} cfg_t;

	typedef struct packed {
		logic        send_open;
		logic        send_keepalive;
		logic        send_notify;
		logic [2:0]  notify_code;
		logic [2:0]  notify_subcode;
		logic        session_up;
		logic        session_down;
		logic [2:0]  result_status;
		logic [1:0]  state_after;
		logic [15:0] open_as_field;
		logic [31:0] peer_router_id;
		logic [31:0] peer_as_number;
	} result_t;

	// seconds to milliseconds
	function automatic logic [MS_W-1:0] ms_of(input logic [15:0] s);
		logic [MS_W-1:0] p;
		p = {{(MS_W-16){1'b0}}, s} * MS_PER_S;
		return p;
	endfunction

	// seconds divided by three
	function automatic logic [14:0] third_of(input logic [15:0] s);
		logic [32:0] p;
		p = {17'b0, s} * THIRD_RECIP;
		return p[THIRD_SHIFT+14:THIRD_SHIFT];
	endfunction

	// keepalive interval: the hold-derived value capped by the configured one, unless that is zero
	function automatic logic [MS_W-1:0] cap_ka(input logic [MS_W-1:0] third_ms,
			input logic [MS_W-1:0] ka_cfg_ms);
		logic [MS_W-1:0] r;
		if (ka_cfg_ms == '0 || third_ms < ka_cfg_ms) begin
			r = third_ms;
		end else begin
			r = ka_cfg_ms;
		end
		return r;
	endfunction

endpackage

/* hdl/bgpfsm_step.sv */
// bgpfsm_step: next session state and result for one event
// depends on bgpfsm_pkg
`timescale 1ns / 1ps

module bgpfsm_step (
	input  bgpfsm_pkg::item_t             item,
	input  logic [bgpfsm_pkg::MS_W-1:0]   hold_ms,
	input  logic [bgpfsm_pkg::MS_W-1:0]   eff_in_ms,
	input  bgpfsm_pkg::cfg_t              cfg,
	input  bgpfsm_pkg::sess_t             st,
	output bgpfsm_pkg::sess_t             nx,
	output bgpfsm_pkg::result_t           res
);

	logic [2:0]  kind;
	logic        open_ok;
	logic [2:0]  open_sub;
	logic [2:0]  open_status;
	logic        no_hold;
	logic        sess_up;
	logic [63:0] heard_elapsed;
	logic [63:0] ka_elapsed;
	logic        hold_expired;
	logic        ka_due;

	// kinds above other fold onto other
	always_comb begin
		if (item.kind inside {[3'd5:3'd7]}) begin
			kind = bgpfsm_pkg::PK_OTHER;
		end else begin
			kind = item.kind;
		end
	end

	// open checks, in priority order
	always_comb begin
		open_ok = 1'b0;
		open_sub = bgpfsm_pkg::SUB_NONE;
		open_status = bgpfsm_pkg::RS_OK;
		if (item.version != bgpfsm_pkg::BGP_VERSION) begin
			open_sub = bgpfsm_pkg::SUB_BAD_VERSION;
			open_status = bgpfsm_pkg::RS_BAD_VERSION;
		end else if (item.hold != '0 && item.hold < bgpfsm_pkg::HOLD_MIN) begin
			open_sub = bgpfsm_pkg::SUB_BAD_HOLD;
			open_status = bgpfsm_pkg::RS_INVALID;
		end else if (item.router_id == '0) begin
			open_sub = bgpfsm_pkg::SUB_BAD_ROUTER_ID;
			open_status = bgpfsm_pkg::RS_INVALID;
		end else begin
			open_ok = 1'b1;
		end
	end

	// timers
	assign no_hold = (cfg.pl_ms == '0) || (item.hold == '0);
	assign sess_up = st.sess inside {bgpfsm_pkg::ST_OPEN_CONFIRM, bgpfsm_pkg::ST_ESTABLISHED};
	assign heard_elapsed = item.now - st.last_heard;
	assign ka_elapsed = item.now - st.last_ka;
	assign hold_expired = (st.hold_ms != '0) && sess_up &&
		(heard_elapsed > {{(64-bgpfsm_pkg::MS_W){1'b0}}, st.hold_ms});
	assign ka_due = sess_up && (st.ka_ms != '0) &&
		(ka_elapsed >= {{(64-bgpfsm_pkg::MS_W){1'b0}}, st.ka_ms});

	// event handling
	always_comb begin
		nx = st;
		res = '0;
		case (item.cmd)
			bgpfsm_pkg::CMD_START: begin
				if (st.sess == bgpfsm_pkg::ST_IDLE) begin
					nx.sess = bgpfsm_pkg::ST_OPEN_SENT;
					nx.remote_as = '0;
					nx.remote_id = '0;
					nx.hold_ms = cfg.pl_ms;
					nx.ka_ms = cfg.eff_pl_ms;
					nx.clock_valid = 1'b0;
					res.send_open = 1'b1;
				end
			end
			bgpfsm_pkg::CMD_STOP: begin
				if (st.sess != bgpfsm_pkg::ST_IDLE) begin
					res.send_notify = 1'b1;
					res.notify_code = bgpfsm_pkg::ERR_CEASE;
					res.notify_subcode = bgpfsm_pkg::SUB_NONE;
				end
				if (st.sess == bgpfsm_pkg::ST_ESTABLISHED) begin
					res.session_down = 1'b1;
				end
				nx.sess = bgpfsm_pkg::ST_IDLE;
				nx.clock_valid = 1'b0;
			end
			bgpfsm_pkg::CMD_PACKET: begin
				if (kind == bgpfsm_pkg::PK_NOTIFY) begin
					nx.sess = bgpfsm_pkg::ST_IDLE;
					if (st.sess == bgpfsm_pkg::ST_ESTABLISHED) begin
						nx.clock_valid = 1'b0;
						res.session_down = 1'b1;
					end
				end else if (kind == bgpfsm_pkg::PK_OPEN &&
						(st.sess == bgpfsm_pkg::ST_IDLE ||
						st.sess == bgpfsm_pkg::ST_OPEN_SENT)) begin
					// open received before confirm
					if (open_ok) begin
						nx.remote_as = item.as_num;
						nx.remote_id = item.router_id;
						if (no_hold) begin
							nx.hold_ms = '0;
							nx.ka_ms = '0;
						end else begin
							nx.hold_ms = (cfg.pl_ms < hold_ms) ? cfg.pl_ms : hold_ms;
							nx.ka_ms = (cfg.eff_pl_ms < eff_in_ms) ? cfg.eff_pl_ms : eff_in_ms;
						end
						nx.sess = bgpfsm_pkg::ST_OPEN_CONFIRM;
						nx.last_heard = '0;
						nx.last_ka = '0;
						nx.clock_valid = 1'b0;
						res.send_keepalive = 1'b1;
						res.send_open = (st.sess == bgpfsm_pkg::ST_IDLE);
					end else begin
						nx.sess = bgpfsm_pkg::ST_IDLE;
						res.send_notify = 1'b1;
						res.notify_code = bgpfsm_pkg::ERR_OPEN;
						res.notify_subcode = open_sub;
						res.result_status = open_status;
					end
				end else begin
					case (st.sess)
						bgpfsm_pkg::ST_IDLE: begin
							// stray traffic is dropped
						end
						bgpfsm_pkg::ST_OPEN_SENT: begin
							nx.sess = bgpfsm_pkg::ST_IDLE;
							res.send_notify = 1'b1;
							res.notify_code = bgpfsm_pkg::ERR_FSM;
							res.notify_subcode = bgpfsm_pkg::SUB_FSM_OPEN_SENT;
							res.result_status = bgpfsm_pkg::RS_BAD_TYPE;
						end
						bgpfsm_pkg::ST_OPEN_CONFIRM: begin
							if (kind == bgpfsm_pkg::PK_KEEPALIVE) begin
								if (st.clock_valid) begin
									nx.last_heard = st.clock_now;
								end
								nx.sess = bgpfsm_pkg::ST_ESTABLISHED;
								res.session_up = 1'b1;
							end else begin
								nx.sess = bgpfsm_pkg::ST_IDLE;
								nx.clock_valid = 1'b0;
								res.send_notify = 1'b1;
								res.notify_code = bgpfsm_pkg::ERR_FSM;
								res.notify_subcode = bgpfsm_pkg::SUB_FSM_CONFIRM;
								res.result_status = bgpfsm_pkg::RS_BAD_TYPE;
							end
						end
						default: begin
							// established
							if (kind == bgpfsm_pkg::PK_KEEPALIVE ||
									kind == bgpfsm_pkg::PK_UPDATE) begin
								if (st.clock_valid) begin
									nx.last_heard = st.clock_now;
								end
								if (kind == bgpfsm_pkg::PK_UPDATE) begin
									res.result_status = bgpfsm_pkg::RS_UPDATE;
								end
							end else begin
								nx.sess = bgpfsm_pkg::ST_IDLE;
								nx.clock_valid = 1'b0;
								res.send_notify = 1'b1;
								res.notify_code = bgpfsm_pkg::ERR_FSM;
								res.notify_subcode = bgpfsm_pkg::SUB_FSM_ESTAB;
								res.result_status = bgpfsm_pkg::RS_BAD_TYPE;
								res.session_down = 1'b1;
							end
						end
					endcase
				end
			end
			default: begin
				// tick
				if (!st.clock_valid) begin
					nx.clock_now = item.now;
					nx.last_heard = item.now;
					nx.last_ka = item.now;
					nx.clock_valid = 1'b1;
				end else begin
					nx.clock_now = item.now;
					if (hold_expired) begin
						nx.sess = bgpfsm_pkg::ST_IDLE;
						nx.clock_valid = 1'b0;
						res.send_notify = 1'b1;
						res.notify_code = bgpfsm_pkg::ERR_HOLD;
						res.notify_subcode = bgpfsm_pkg::SUB_NONE;
						res.session_down = 1'b1;
					end else if (ka_due) begin
						res.send_keepalive = 1'b1;
						nx.last_ka = item.now;
					end
				end
			end
		endcase

		// fields reported with every result; the open AS field only with an open send
		if (res.send_open) begin
			if (cfg.four_byte && cfg.local_as > bgpfsm_pkg::AS16_MAX) begin
				res.open_as_field = bgpfsm_pkg::AS_TRANS;
			end else begin
				res.open_as_field = cfg.local_as[15:0];
			end
		end
		res.state_after = nx.sess;
		res.peer_router_id = nx.remote_id;
		res.peer_as_number = nx.remote_as;
	end

endmodule

/* hdl/bgp_session_fsm.sv */
// bgp_session_fsm: top level of the bgp session controller
// depends on bgpfsm_pkg and bgpfsm_step
// a result is registered after its item passes the input register, the two timer-prep stages
// and the session update stage; throughput: one item per cycle while results are taken
// reset: arst_n clears the session to idle and the clock and timestamps to zero, and sets
// the hold and keepalive intervals and the configuration registers to their defaults;
// derived timer values are registered from the configuration registers
`timescale 1ns / 1ps

module bgp_session_fsm (
	input  logic         clk,
	input  logic         arst_n,
	// configuration writes
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// event items
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// open_version, open_hold_seconds, open_router_id, open_as_number, now_ms
	input  logic [151:0] s_axis_tdata,
	// cmd, packet_kind
	input  logic [4:0]   s_axis_tuser,
	// result items
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// send_open, send_keepalive, send_notify, notify_code, notify_subcode, session_up,
	// session_down, result_status, state_after, open_as_field, peer_router_id,
	// peer_as_number
	output logic [95:0]  m_axis_tdata
);

	localparam int MS_W = bgpfsm_pkg::MS_W;

	logic [31:0]     local_as_q;
	logic [15:0]     local_hold_q;
	logic [15:0]     keepalive_q;
	logic            four_byte_q;
	logic [MS_W-1:0] pl_ms_q;
	logic [14:0]     pl_third_q;
	logic [MS_W-1:0] ka_cfg_ms_q;
	logic [MS_W-1:0] eff_pl_ms_q;
	logic [14:0]     pl_third_min;

	bgpfsm_pkg::item_t   item_in;
	bgpfsm_pkg::item_t   item_s1;
	bgpfsm_pkg::item_t   item_s2;
	bgpfsm_pkg::item_t   item_s3;
	logic                v_s1;
	logic                v_s2;
	logic                v_s3;
	logic [MS_W-1:0]     hold_ms_s2;
	logic [14:0]         third_s2;
	logic [MS_W-1:0]     hold_ms_s3;
	logic [MS_W-1:0]     eff_in_ms_s3;
	logic [14:0]         third_min;

	bgpfsm_pkg::sess_t   st_q;
	bgpfsm_pkg::sess_t   st_nx;
	bgpfsm_pkg::cfg_t    cfg;
	bgpfsm_pkg::result_t res_nx;
	bgpfsm_pkg::result_t out_q;
	logic                out_v_q;

	logic acc;
	logic adv1;
	logic adv2;
	logic adv3;
	logic free1;
	logic free2;
	logic free3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_as_q <= bgpfsm_pkg::RST_LOCAL_AS;
			local_hold_q <= bgpfsm_pkg::RST_LOCAL_HLD;
			keepalive_q <= bgpfsm_pkg::RST_KEEPALIVE;
			four_byte_q <= bgpfsm_pkg::RST_FOUR_BYTE;
		end else if (cfg_we) begin
			case (cfg_index)
				bgpfsm_pkg::CFG_LOCAL_AS:   local_as_q <= cfg_data;
				bgpfsm_pkg::CFG_LOCAL_HOLD: local_hold_q <= cfg_data[15:0];
				bgpfsm_pkg::CFG_KEEPALIVE:  keepalive_q <= cfg_data[15:0];
				default:                    four_byte_q <= cfg_data[0];
			endcase
		end
	end

	// local hold and keepalive in milliseconds, registered from the configuration registers
	assign pl_third_min = (pl_third_q == '0) ? 15'd1 : pl_third_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_ms_q <= bgpfsm_pkg::RST_HOLD_MS;
			pl_third_q <= bgpfsm_pkg::RST_THIRD;
			ka_cfg_ms_q <= bgpfsm_pkg::RST_KA_MS;
			eff_pl_ms_q <= bgpfsm_pkg::RST_KA_MS;
		end else begin
			pl_ms_q <= bgpfsm_pkg::ms_of(local_hold_q);
			pl_third_q <= bgpfsm_pkg::third_of(local_hold_q);
			ka_cfg_ms_q <= bgpfsm_pkg::ms_of(keepalive_q);
			if (local_hold_q == '0) begin
				eff_pl_ms_q <= '0;
			end else begin
				eff_pl_ms_q <= bgpfsm_pkg::cap_ka(bgpfsm_pkg::ms_of({1'b0, pl_third_min}),
					ka_cfg_ms_q);
			end
		end
	end

	assign cfg.local_as = local_as_q;
	assign cfg.four_byte = four_byte_q;
	assign cfg.pl_ms = pl_ms_q;
	assign cfg.eff_pl_ms = eff_pl_ms_q;

	// input unpacking
	assign item_in.cmd = s_axis_tuser[1:0];
	assign item_in.kind = s_axis_tuser[4:2];
	assign item_in.version = s_axis_tdata[7:0];
	assign item_in.hold = s_axis_tdata[23:8];
	assign item_in.router_id = s_axis_tdata[55:24];
	assign item_in.as_num = s_axis_tdata[87:56];
	assign item_in.now = s_axis_tdata[151:88];

	// pipeline flow: each stage moves when the next one has room
	assign adv3 = v_s3 && (!out_v_q || m_axis_tready);
	assign free3 = !v_s3 || adv3;
	assign adv2 = v_s2 && free3;
	assign free2 = !v_s2 || adv2;
	assign adv1 = v_s1 && free2;
	assign free1 = !v_s1 || adv1;
	assign s_axis_tready = free1;
	assign acc = s_axis_tvalid && free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (adv3) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item_in;
		end
	end

	// stage 2: peer hold time in ms and a third of it
	always_ff @(posedge clk) begin
		if (adv1) begin
			item_s2 <= item_s1;
			hold_ms_s2 <= bgpfsm_pkg::ms_of(item_s1.hold);
			third_s2 <= bgpfsm_pkg::third_of(item_s1.hold);
		end
	end

	// stage 3: keepalive interval the peer hold time would give, capped by the configured keepalive
	assign third_min = (third_s2 == '0) ? 15'd1 : third_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			item_s3 <= item_s2;
			hold_ms_s3 <= hold_ms_s2;
			if (item_s2.hold == '0) begin
				eff_in_ms_s3 <= '0;
			end else begin
				eff_in_ms_s3 <= bgpfsm_pkg::cap_ka(bgpfsm_pkg::ms_of({1'b0, third_min}),
					ka_cfg_ms_q);
			end
		end
	end

	// session update
	bgpfsm_step u_step (
		.item      (item_s3),
		.hold_ms   (hold_ms_s3),
		.eff_in_ms (eff_in_ms_s3),
		.cfg       (cfg),
		.st        (st_q),
		.nx        (st_nx),
		.res       (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.sess <= bgpfsm_pkg::ST_IDLE;
			st_q.remote_as <= '0;
			st_q.remote_id <= '0;
			st_q.hold_ms <= bgpfsm_pkg::RST_HOLD_MS;
			st_q.ka_ms <= bgpfsm_pkg::RST_KA_MS;
			st_q.clock_now <= '0;
			st_q.last_heard <= '0;
			st_q.last_ka <= '0;
			st_q.clock_valid <= 1'b0;
		end else if (adv3) begin
			st_q <= st_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv3) begin
			out_q <= res_nx;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {out_q.peer_as_number, out_q.peer_router_id, out_q.open_as_field,
		out_q.state_after, out_q.result_status, out_q.session_down, out_q.session_up,
		out_q.notify_subcode, out_q.notify_code, out_q.send_notify, out_q.send_keepalive,
		out_q.send_open};

endmodule

/* hdl/bgpfsm_checker.sv */
// bgpfsm_checker: port-level checks on the result stream of bgp_session_fsm
// depends on bgpfsm_pkg; attached to the top level by the bind at the end
`timescale 1ns / 1ps

module bgpfsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata
);

	logic        send_open;
	logic        send_notify;
	logic [2:0]  notify_code;
	logic [2:0]  notify_subcode;
	logic        session_up;
	logic        session_down;
	logic [1:0]  state_after;
	logic [15:0] open_as_field;

	assign send_open = m_axis_tdata[0];
	assign send_notify = m_axis_tdata[2];
	assign notify_code = m_axis_tdata[5:3];
	assign notify_subcode = m_axis_tdata[8:6];
	assign session_up = m_axis_tdata[9];
	assign session_down = m_axis_tdata[10];
	assign state_after = m_axis_tdata[15:14];
	assign open_as_field = m_axis_tdata[31:16];

	// a stalled result item holds
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// session up only on entering established
	a_up_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && session_up |-> state_after == bgpfsm_pkg::ST_ESTABLISHED)
		else $error("session up without established state");

	// teardown always lands in idle
	a_down_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && session_down |-> state_after == bgpfsm_pkg::ST_IDLE)
		else $error("session down without idle state");

	// no code without a notification
	a_notify_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !send_notify |->
		notify_code == bgpfsm_pkg::ERR_NONE && notify_subcode == bgpfsm_pkg::SUB_NONE)
		else $error("notification code without notification");

	// open AS field only with an open send
	a_open_as: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !send_open |-> open_as_field == '0)
		else $error("open AS field set without open send");

endmodule

bind bgp_session_fsm bgpfsm_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
